### rtl/cbnt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cbnt_pkg - shared types and constants for the conditional nesting tracker
// Directive codes, decoded command, result beat and sizing constants.
// ============================================================================
package cbnt_pkg;

    // Deepest nesting of open conditional levels
    localparam int MAX_DEPTH   = 20;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int LVL_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OPCODE_W    = 3;
    localparam int OUT_DEPTH_W = 6;
    localparam int SKIP_W      = 16;

    // Command queue between front and back
    localparam int CMDQ_DEPTH  = 4;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // Result queue at the output
    localparam int RESQ_DEPTH  = 2;
    localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

    // Directive codes as they arrive on the input
    typedef enum logic [OPCODE_W-1:0] {
        OPC_IF     = 3'd0,
        OPC_ELSEIF = 3'd1,
        OPC_ELSE   = 3'd2,
        OPC_ENDIF  = 3'd3,
        OPC_EOM    = 3'd4
    } t_opcode;

    // Decoded command class; unused codes become a no-op
    typedef enum logic [2:0] {
        CMD_IF     = 3'd0,
        CMD_ELSEIF = 3'd1,
        CMD_ELSE   = 3'd2,
        CMD_ENDIF  = 3'd3,
        CMD_EOM    = 3'd4,
        CMD_NOP    = 3'd5
    } t_cmd_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_TOO_DEEP   = 3'd1,
        ERR_ELSE_SEEN  = 3'd2,
        ERR_NO_BLOCK   = 3'd3,
        ERR_STILL_OPEN = 3'd4
    } t_err;

    typedef enum logic [1:0] {
        BLK_ACTIVE   = 2'd0,
        BLK_INACTIVE = 2'd1,
        BLK_DONE     = 2'd2
    } t_blk;

    typedef struct packed {
        t_cmd_kind kind;
        logic      cond_true;
        logic      cond_ok;
    } t_cmd;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_head;

    typedef struct packed {
        logic                   assembling;
        logic [OUT_DEPTH_W-1:0] depth;
        t_err                   err;
    } t_res;

endpackage

### rtl/cbnt_front.sv
`timescale 1ns / 1ps
// ============================================================================
// cbnt_front - directive intake and decode
// Accepts directive beats, classifies the opcode and queues the command.
// ============================================================================
module cbnt_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [cbnt_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic                              i_cond_true,
    input  logic                              i_cond_ok,
    output cbnt_pkg::t_cmd_head               o_head,
    input  logic                              i_take
);

    cbnt_pkg::t_cmd                        r_q [cbnt_pkg::CMDQ_DEPTH];
    logic [cbnt_pkg::CMDQ_PTR_W-1:0]       r_wr, n_wr;
    logic [cbnt_pkg::CMDQ_PTR_W-1:0]       r_rd, n_rd;
    logic [cbnt_pkg::CMDQ_CNT_W-1:0]       r_cnt, n_cnt;
    cbnt_pkg::t_cmd                        dec;
    logic                                  wr_en;
    logic                                  rd_en;

    assign full  = (r_cnt == cbnt_pkg::CMDQ_CNT_W'(cbnt_pkg::CMDQ_DEPTH));
    assign wr_en = push && !full;
    assign rd_en = i_take && (r_cnt != '0);

    always_comb begin
        dec.cond_true = i_cond_true;
        dec.cond_ok   = i_cond_ok;
        unique case (i_opcode)
            cbnt_pkg::OPC_IF:     dec.kind = cbnt_pkg::CMD_IF;
            cbnt_pkg::OPC_ELSEIF: dec.kind = cbnt_pkg::CMD_ELSEIF;
            cbnt_pkg::OPC_ELSE:   dec.kind = cbnt_pkg::CMD_ELSE;
            cbnt_pkg::OPC_ENDIF:  dec.kind = cbnt_pkg::CMD_ENDIF;
            cbnt_pkg::OPC_EOM:    dec.kind = cbnt_pkg::CMD_EOM;
            default:              dec.kind = cbnt_pkg::CMD_NOP;
        endcase
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (wr_en) begin
            n_wr = (r_wr == cbnt_pkg::CMDQ_PTR_W'(cbnt_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == cbnt_pkg::CMDQ_PTR_W'(cbnt_pkg::CMDQ_DEPTH - 1)) ? '0
                                                                          : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= dec;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rd];

endmodule

### rtl/cbnt_back.sv
`timescale 1ns / 1ps
// ============================================================================
// cbnt_back - nesting state update and result queue
// Applies one command per cycle, while the result queue has room, to the block state and queues the result.
// ============================================================================
module cbnt_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbnt_pkg::t_cmd_head               i_head,
    output logic                              o_take,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_assembling,
    output logic [cbnt_pkg::OUT_DEPTH_W-1:0]  o_depth,
    output logic [2:0]                        o_error_code
);

    // Architectural state
    cbnt_pkg::t_blk                     r_blk, n_blk;
    logic [cbnt_pkg::DEPTH_W-1:0]       r_depth, n_depth;
    logic [cbnt_pkg::SKIP_W-1:0]        r_skip, n_skip;
    logic [cbnt_pkg::MAX_DEPTH-1:0]     r_marks;

    // Result queue
    cbnt_pkg::t_res                     r_rq [cbnt_pkg::RESQ_DEPTH];
    logic [cbnt_pkg::RESQ_PTR_W-1:0]    r_wr, n_wr;
    logic [cbnt_pkg::RESQ_PTR_W-1:0]    r_rd, n_rd;
    logic [cbnt_pkg::RESQ_CNT_W-1:0]    r_cnt, n_cnt;

    cbnt_pkg::t_err                     err;
    cbnt_pkg::t_res                     res;
    logic                               eval;
    logic                               mark_clr;
    logic                               mark_set;
    logic [cbnt_pkg::DEPTH_W-1:0]       depth_m1;
    logic [cbnt_pkg::LVL_W-1:0]         lvl_cur;
    logic [cbnt_pkg::LVL_W-1:0]         lvl_top;
    logic                               pop_en;
    logic                               room;

    assign pop_en = pop && !empty;
    assign empty  = (r_cnt == '0);
    // A slot frees up in the same cycle the head is popped
    assign room   = (r_cnt != cbnt_pkg::RESQ_CNT_W'(cbnt_pkg::RESQ_DEPTH)) || pop_en;
    assign o_take = i_head.valid && room;

    assign depth_m1 = r_depth - 1'b1;
    assign lvl_cur  = r_depth[cbnt_pkg::LVL_W-1:0];
    assign lvl_top  = depth_m1[cbnt_pkg::LVL_W-1:0];

    always_comb begin
        n_blk    = r_blk;
        n_depth  = r_depth;
        n_skip   = r_skip;
        err      = cbnt_pkg::ERR_NONE;
        eval     = 1'b0;
        mark_clr = 1'b0;
        mark_set = 1'b0;
        unique case (i_head.cmd.kind)
            cbnt_pkg::CMD_IF: begin
                if (r_blk != cbnt_pkg::BLK_ACTIVE) begin
                    if (r_skip != '1) begin
                        n_skip = r_skip + 1'b1;
                    end
                end else begin
                    if (r_depth >= cbnt_pkg::DEPTH_W'(cbnt_pkg::MAX_DEPTH)) begin
                        err = cbnt_pkg::ERR_TOO_DEEP;
                    end else begin
                        mark_clr = 1'b1;
                        n_depth  = r_depth + 1'b1;
                    end
                    eval = 1'b1;
                end
            end
            cbnt_pkg::CMD_ELSEIF, cbnt_pkg::CMD_ELSE: begin
                if (r_depth == '0) begin
                    err  = cbnt_pkg::ERR_NO_BLOCK;
                    eval = (i_head.cmd.kind == cbnt_pkg::CMD_ELSEIF);
                end else if (r_skip != '0) begin
                    // inside skipped IFs: nothing moves
                    eval = 1'b0;
                end else if (r_marks[lvl_top]) begin
                    err  = cbnt_pkg::ERR_ELSE_SEEN;
                    eval = (i_head.cmd.kind == cbnt_pkg::CMD_ELSEIF);
                end else begin
                    n_blk    = (r_blk == cbnt_pkg::BLK_INACTIVE) ? cbnt_pkg::BLK_ACTIVE
                                                                 : cbnt_pkg::BLK_DONE;
                    mark_set = (i_head.cmd.kind == cbnt_pkg::CMD_ELSE);
                    eval     = (i_head.cmd.kind == cbnt_pkg::CMD_ELSEIF);
                end
            end
            cbnt_pkg::CMD_ENDIF: begin
                if (r_depth == '0) begin
                    err = cbnt_pkg::ERR_NO_BLOCK;
                end else if (r_skip != '0) begin
                    n_skip = r_skip - 1'b1;
                end else begin
                    n_depth = depth_m1;
                    n_blk   = cbnt_pkg::BLK_ACTIVE;
                end
            end
            cbnt_pkg::CMD_EOM: begin
                if (r_depth != '0) begin
                    err = cbnt_pkg::ERR_STILL_OPEN;
                end
            end
            default: begin
                err = cbnt_pkg::ERR_NONE;
            end
        endcase

        // condition evaluation follows the nesting update
        if (eval && i_head.cmd.cond_ok && (n_blk == cbnt_pkg::BLK_ACTIVE)) begin
            n_blk = i_head.cmd.cond_true ? cbnt_pkg::BLK_ACTIVE : cbnt_pkg::BLK_INACTIVE;
        end

        res.assembling = (n_blk == cbnt_pkg::BLK_ACTIVE);
        res.depth      = cbnt_pkg::OUT_DEPTH_W'(n_depth);
        res.err        = err;
    end

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (o_take) begin
            n_wr = (r_wr == cbnt_pkg::RESQ_PTR_W'(cbnt_pkg::RESQ_DEPTH - 1)) ? '0
                                                                          : r_wr + 1'b1;
        end
        if (pop_en) begin
            n_rd = (r_rd == cbnt_pkg::RESQ_PTR_W'(cbnt_pkg::RESQ_DEPTH - 1)) ? '0
                                                                          : r_rd + 1'b1;
        end
        if (o_take && !pop_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop_en && !o_take) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk   <= cbnt_pkg::BLK_ACTIVE;
            r_depth <= '0;
            r_skip  <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
        end else begin
            if (o_take) begin
                r_blk   <= n_blk;
                r_depth <= n_depth;
                r_skip  <= n_skip;
            end
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // else-seen marks: written by IF and ELSE only, no reset
    always_ff @(posedge i_clk) begin
        if (o_take && mark_clr) begin
            r_marks[lvl_cur] <= 1'b0;
        end
        if (o_take && mark_set) begin
            r_marks[lvl_top] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rq[r_wr] <= res;
        end
    end

    assign o_assembling = r_rq[r_rd].assembling;
    assign o_depth      = r_rq[r_rd].depth;
    assign o_error_code = r_rq[r_rd].err;

endmodule

### rtl/conditional_block_nesting_tracker.sv
`timescale 1ns / 1ps
// ============================================================================
// conditional_block_nesting_tracker - IF/ELSEIF/ELSE/ENDIF nesting tracker
// Tracks conditional-assembly nesting and reports assembling, depth, error.
// ============================================================================
//
//  channel   | handshake          | beat fields
//  ----------+--------------------+--------------------------------------------
//  directive | push / full        | i_opcode, i_cond_true, i_cond_ok
//  result    | empty / pop        | o_assembling, o_depth, o_error_code
//
//  One directive per clock while the result queue has room; one result
//  beat per directive. Each directive passes through the four-entry command
//  queue, then the state update into the two-entry result queue, before its
//  result reaches the head of the result queue.
//  Reset (synchronous, active low) empties both queues and puts the block
//  state to active, depth and skipped-IF count to zero. Else-seen marks
//  carry no reset; an IF clears the mark of each level it opens.
//  A stalled result side backs up the result queue, then the command queue,
//  then raises full; pop and push can stall independently.
//
module conditional_block_nesting_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [cbnt_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic                              i_cond_true,
    input  logic                              i_cond_ok,
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_assembling,
    output logic [cbnt_pkg::OUT_DEPTH_W-1:0]  o_depth,
    output logic [2:0]                        o_error_code
);

    // head of the command queue and the back end's take strobe
    cbnt_pkg::t_cmd_head head;
    logic                take;

    // front: decode opcode, queue commands
    cbnt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_cond_true (i_cond_true),
        .i_cond_ok   (i_cond_ok),
        .o_head      (head),
        .i_take      (take)
    );

    // back: nesting state machine step and result queue
    cbnt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_take       (take),
        .empty        (empty),
        .pop          (pop),
        .o_assembling (o_assembling),
        .o_depth      (o_depth),
        .o_error_code (o_error_code)
    );

endmodule

### rtl/cbnt_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// cbnt_checker - port-level assertions for the nesting tracker
// Checks reset, result hold, error/depth consistency and depth stepping.
// ============================================================================
module cbnt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              full,
    input  logic                              empty,
    input  logic                              pop,
    input  logic                              o_assembling,
    input  logic [cbnt_pkg::OUT_DEPTH_W-1:0]  o_depth,
    input  logic [2:0]                        o_error_code
);

    // reset empties both queues
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // a waiting result beat holds until popped
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_depth) && $stable(o_assembling)
                              && $stable(o_error_code)))
        else $error("result beat changed while stalled");

    // too-deep only at full depth
    a_too_deep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_error_code == cbnt_pkg::ERR_TOO_DEEP))
            |-> (o_depth == cbnt_pkg::OUT_DEPTH_W'(cbnt_pkg::MAX_DEPTH)))
        else $error("too-deep error below full depth");

    // successive results differ in depth by at most one level
    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty) ##1 !empty
            |-> ((o_depth == $past(o_depth)) || (o_depth == $past(o_depth) + 1'b1)
                 || ($past(o_depth) == o_depth + 1'b1)))
        else $error("depth jumped by more than one level");

endmodule

bind conditional_block_nesting_tracker cbnt_checker u_cbnt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_assembling (o_assembling),
    .o_depth      (o_depth),
    .o_error_code (o_error_code)
);
